### hw/rtl/slot_occupancy_map_core_macros.svh
// Assertion macros shared by the slot occupancy map RTL.
`ifndef SLOT_OCCUPANCY_MAP_CORE_MACROS_SVH
`define SLOT_OCCUPANCY_MAP_CORE_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define SOC_CHECK(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("slot occupancy map check failed");

// Check that a condition implies another in the same cycle.
`define SOC_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot occupancy map implication failed");

`endif

### hw/rtl/som_pkg.sv
// Shared types, field widths and codes of the slot occupancy map.
package som_pkg;

    localparam int MODE_W = 3;
    localparam int SLOT_W = 7;
    localparam int STAT_W = 2;
    localparam int RES_W  = 6;
    localparam int CNT_W  = 7;
    localparam int SLOTS_DEFAULT = 16;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STORE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PREV  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic clr_all;
        logic set;
        logic clr;
        logic load;
        logic shift;
        logic fwd;
        logic want_free;
    } t_cell_ctl;

endpackage

### hw/rtl/som_cell.sv
// One slot cell: occupied mark and a search token passed to its neighbors.
module som_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  som_pkg::t_cell_ctl i_ctl,
    input  logic              i_sel,
    input  logic              i_tok_prev,
    input  logic              i_tok_next,
    output logic              o_tok,
    output logic              o_occ,
    output logic              o_hit
);

    logic r_occ;
    logic r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.clr_all) begin
            r_occ <= 1'b0;
        end else if (i_sel && i_ctl.set) begin
            r_occ <= 1'b1;
        end else if (i_sel && i_ctl.clr) begin
            r_occ <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.load) begin
            r_tok <= i_sel;
        end else if (i_ctl.shift) begin
            r_tok <= i_ctl.fwd ? i_tok_prev : i_tok_next;
        end
    end

    assign o_tok = r_tok;
    assign o_occ = r_occ;
    assign o_hit = r_tok && (i_ctl.want_free ? !r_occ : r_occ);

endmodule

### hw/rtl/slot_occupancy_map_core.sv
// Slot occupancy map top level: command sequencer driving a ring of slot cells.
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser mode, tdata slot, from_start
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tuser status, tdata slot, count
//
// Clear, store at slot, delete and unused modes go from S_START straight to S_FIN and then to the output register.
// Store at first free and next/previous search pass a token one cell per cycle
// around the ring in S_SCAN, until a cell hits or the token has visited every cell.
// A new command is taken while a finished result still waits in the output register.
// Synchronous active-low reset frees every slot and empties the output register.
`include "slot_occupancy_map_core_macros.svh"

module slot_occupancy_map_core #(
    parameter int SLOTS = som_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] slot, [7] from_start
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] result_slot, [12:6] occupied_count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [som_pkg::MODE_W-1:0] r_mode;
    logic [som_pkg::SLOT_W-1:0] r_slot;
    logic                      r_fs;
    logic [IW-1:0]             r_pos;
    logic [IW-1:0]             n_pos;
    logic [IW-1:0]             r_k;
    logic [IW-1:0]             n_k;
    logic [som_pkg::CNT_W-1:0]  r_count;
    logic [som_pkg::CNT_W-1:0]  n_count;
    logic [som_pkg::STAT_W-1:0] r_status;
    logic [som_pkg::STAT_W-1:0] n_status;
    logic [IW-1:0]             r_res;
    logic [IW-1:0]             n_res;
    logic                      r_ovalid;
    logic [som_pkg::STAT_W-1:0] r_ostatus;
    logic [som_pkg::RES_W-1:0]  r_oslot;
    logic [som_pkg::CNT_W-1:0]  r_ocount;

    som_pkg::t_cell_ctl        w_ctl;
    logic [IW-1:0]             w_sel_idx;
    logic [IW-1:0]             w_slot_idx;
    logic [IW-1:0]             w_start;
    logic                      w_in_range;
    logic                      w_is_search;
    logic                      w_hit;
    logic                      w_load_out;
    logic [SLOTS-1:0]          w_tok;
    logic [SLOTS-1:0]          w_occ;
    logic [SLOTS-1:0]          w_hits;

    assign s_axis_tready = (r_state == S_IDLE);

    assign w_in_range = (r_slot < som_pkg::SLOT_W'(SLOTS));
    assign w_slot_idx = r_slot[IW-1:0];
    assign w_hit      = |w_hits;
    assign w_load_out = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);

    always_comb begin
        w_start = '0;
        if (!r_fs && r_mode == som_pkg::MODE_NEXT) begin
            w_start = (w_slot_idx == LAST) ? '0 : w_slot_idx + IW'(1);
        end else if (!r_fs && r_mode == som_pkg::MODE_PREV) begin
            w_start = (w_slot_idx == '0) ? LAST : w_slot_idx - IW'(1);
        end
    end

    assign w_is_search = (r_mode == som_pkg::MODE_FIRST)
        || ((r_mode == som_pkg::MODE_NEXT || r_mode == som_pkg::MODE_PREV)
            && (r_fs || w_in_range));

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_k      = r_k;
        n_count  = r_count;
        n_status = r_status;
        n_res    = r_res;
        w_ctl    = '0;
        w_ctl.fwd       = (r_mode != som_pkg::MODE_PREV);
        w_ctl.want_free = (r_mode == som_pkg::MODE_FIRST);
        w_sel_idx = r_pos;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_status = som_pkg::ST_OK;
                n_res    = '0;
                n_state  = S_FIN;
                if (w_is_search) begin
                    w_sel_idx  = w_start;
                    w_ctl.load = 1'b1;
                    n_pos      = w_start;
                    n_k        = '0;
                    n_state    = S_SCAN;
                end else begin
                    w_sel_idx = w_slot_idx;
                    case (r_mode)
                        som_pkg::MODE_CLEAR: begin
                            w_ctl.clr_all = 1'b1;
                            n_count       = '0;
                        end
                        som_pkg::MODE_STORE: begin
                            if (w_in_range) begin
                                w_ctl.set = 1'b1;
                                n_res     = w_slot_idx;
                                n_count   = r_count
                                    + som_pkg::CNT_W'(!w_occ[w_slot_idx]);
                            end else begin
                                n_status = som_pkg::ST_RANGE;
                            end
                        end
                        som_pkg::MODE_DEL: begin
                            if (w_in_range) begin
                                w_ctl.clr = 1'b1;
                                n_count   = r_count
                                    - som_pkg::CNT_W'(w_occ[w_slot_idx]);
                            end else begin
                                n_status = som_pkg::ST_RANGE;
                            end
                        end
                        som_pkg::MODE_NEXT, som_pkg::MODE_PREV: begin
                            n_status = som_pkg::ST_RANGE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res   = r_pos;
                    n_state = S_FIN;
                    if (r_mode == som_pkg::MODE_FIRST) begin
                        w_ctl.set = 1'b1;
                        n_count   = r_count + som_pkg::CNT_W'(1);
                    end
                end else if (r_k == LAST) begin
                    n_status = (r_mode == som_pkg::MODE_FIRST)
                        ? som_pkg::ST_FULL : som_pkg::ST_NONE;
                    n_state  = S_FIN;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_k         = r_k + IW'(1);
                    if (w_ctl.fwd) begin
                        n_pos = (r_pos == LAST) ? '0 : r_pos + IW'(1);
                    end else begin
                        n_pos = (r_pos == '0) ? LAST : r_pos - IW'(1);
                    end
                end
            end
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        som_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_sel      (w_sel_idx == IW'(i)),
            .i_tok_prev (w_tok[(i + SLOTS - 1) % SLOTS]),
            .i_tok_next (w_tok[(i + 1) % SLOTS]),
            .o_tok      (w_tok[i]),
            .o_occ      (w_occ[i]),
            .o_hit      (w_hits[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode <= s_axis_tuser;
            r_slot <= s_axis_tdata[6:0];
            r_fs   <= s_axis_tdata[7];
        end
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_status <= n_status;
        r_res    <= n_res;
        if (w_load_out) begin
            r_ostatus <= r_status;
            r_oslot   <= som_pkg::RES_W'(r_res);
            r_ocount  <= r_count;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {3'b000, r_ocount, r_oslot};

    `SOC_CHECK(a_tok_single, $onehot0(w_tok))
    `SOC_IMPLY(a_tok_in_scan, r_state == S_SCAN, $onehot(w_tok))
    `SOC_CHECK(a_count_match, r_count == som_pkg::CNT_W'($countones(w_occ)))
    `SOC_IMPLY(a_ready_idle, s_axis_tready, !w_ctl.shift && !w_ctl.set && !w_ctl.clr)

endmodule
